[hdl/lbe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_pkg
// Shared types and constants of the life board engine.
// ----------------------------------------------------------------------------
package lbe_pkg;

  localparam int COL_W      = 6;
  localparam int ROW_W      = 6;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;
  localparam int NBR_W      = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_ADVANCE = 2'd2
  } lbe_mode_t;

  localparam logic [CFG_IDX_W-1:0]  REG_BOARD_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_BOARD_HEIGHT = 8'd1;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET        = 7'd64;

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

endpackage

[hdl/lbe_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_ifs
// Stream and configuration channels of the life board engine.
// ----------------------------------------------------------------------------
interface lbe_in_if import lbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MODE_W-1:0] mode;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             cell_in;

  modport source (output valid, output mode, output col, output row, output cell_in,
                  input ready);
  modport sink   (input valid, input mode, input col, input row, input cell_in,
                  output ready);
endinterface

interface lbe_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic out_of_range;

  modport source (output valid, output cell_out, output out_of_range, input ready);
  modport sink   (input valid, input cell_out, input out_of_range, output ready);
endinterface

interface lbe_cfg_if import lbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/life_automaton_board_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_board_engine_unit
// B3/S23 life board with cell read, cell write and whole-board advance.
// ----------------------------------------------------------------------------
// The board lives in a row-wide RAM, one word per row of MAX_WIDTH cells, and
// every word goes through a single read-modify-write sequencer. After reset a
// clearing pass writes MAX_HEIGHT rows, one per cycle, before the first input
// word is taken; configuration writes are taken during it. A cell read or
// write passes through RAM read, modify and result stage from accept to
// result, and an advance loads the first row, then for each of the H rows in
// use fetches the row below and then computes and writes back the row, the
// registered RAM read on each row fetch being the limit. A new input word is
// taken while the last result still waits on the output.
// ----------------------------------------------------------------------------
module life_automaton_board_engine_unit import lbe_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  lbe_in_if.sink   in_if,
  lbe_out_if.source out_if,
  lbe_cfg_if.sink  cfg_if
);

  localparam int ROW_AW = $clog2(MAX_HEIGHT);
  localparam int COL_AW = $clog2(MAX_WIDTH);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WR_WAIT, ST_RD_WAIT, ST_ADV_LOAD, ST_ADV_RD, ST_ADV_WB, ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [ROW_AW-1:0]     clr_r, clr_nxt;
  logic [CFG_DATA_W-1:0] bw_r, bw_nxt;
  logic [CFG_DATA_W-1:0] bh_r, bh_nxt;
  logic [ROW_AW-1:0]     row_r, row_nxt;
  logic [COL_AW-1:0]     col_r, col_nxt;
  logic                  cell_r, cell_nxt;
  logic [HW-1:0]         r_r, r_nxt;
  logic [MAX_WIDTH-1:0]  above_r, above_nxt;
  logic [MAX_WIDTH-1:0]  cur_r, cur_nxt;
  logic                  res_cell_r, res_cell_nxt;
  logic                  res_oor_r, res_oor_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_cell_r, out_cell_nxt;
  logic                  out_oor_r, out_oor_nxt;

  logic                  ram_we;
  logic [ROW_AW-1:0]     ram_waddr;
  logic [MAX_WIDTH-1:0]  ram_wdata;
  logic [ROW_AW-1:0]     ram_raddr;
  logic [MAX_WIDTH-1:0]  ram_rdata;

  logic [HW-1:0]         used_h;
  logic                  in_range;
  logic                  last_row;
  logic [MAX_WIDTH-1:0]  below;
  logic [MAX_WIDTH-1:0]  gen_row;

  lbe_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_board (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lbe_next_row #(.WIDTH(MAX_WIDTH)) u_next_row (
    .board_width (bw_r),
    .above       (above_r),
    .cur         (cur_r),
    .below       (below),
    .next_row    (gen_row)
  );

  assign used_h   = (32'(bh_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(bh_r);
  assign in_range = (32'(in_if.col) < 32'(bw_r)) && (32'(in_if.col) < MAX_WIDTH)
                 && (32'(in_if.row) < 32'(used_h));
  assign last_row = (32'(r_r) + 32'd1) >= 32'(used_h);
  assign below    = last_row ? '0 : ram_rdata;

  assign in_if.ready   = (state_r == ST_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.cell_out     = out_cell_r;
  assign out_if.out_of_range = out_oor_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    bw_nxt        = bw_r;
    bh_nxt        = bh_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cell_nxt      = cell_r;
    r_nxt         = r_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    res_cell_nxt  = res_cell_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_cell_nxt  = out_cell_r;
    out_oor_nxt   = out_oor_r;
    ram_we        = 1'b0;
    ram_waddr     = row_r;
    ram_wdata     = '0;
    ram_raddr     = row_r;

    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_BOARD_WIDTH:  bw_nxt = cfg_if.data;
        REG_BOARD_HEIGHT: bh_nxt = cfg_if.data;
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == ROW_AW'(MAX_HEIGHT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        row_nxt   = ROW_AW'(in_if.row);
        col_nxt   = COL_AW'(in_if.col);
        cell_nxt  = in_if.cell_in;
        ram_raddr = ROW_AW'(in_if.row);
        if (in_if.valid) begin
          res_cell_nxt = 1'b0;
          res_oor_nxt  = 1'b0;
          state_nxt    = ST_DONE;
          case (in_if.mode)
            MODE_WRITE, MODE_READ: begin
              if (!in_range) begin
                res_oor_nxt = 1'b1;
              end else if (in_if.mode == MODE_WRITE) begin
                state_nxt = ST_WR_WAIT;
              end else begin
                state_nxt = ST_RD_WAIT;
              end
            end
            MODE_ADVANCE: begin
              ram_raddr = '0;
              r_nxt     = '0;
              above_nxt = '0;
              if (used_h != '0) begin
                state_nxt = ST_ADV_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WR_WAIT: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & ~(MAX_WIDTH'(1) << col_r))
                  | (MAX_WIDTH'(cell_r) << col_r);
        state_nxt = ST_DONE;
      end
      ST_RD_WAIT: begin
        res_cell_nxt = ram_rdata[col_r];
        state_nxt    = ST_DONE;
      end
      ST_ADV_LOAD: begin
        cur_nxt   = ram_rdata;
        state_nxt = ST_ADV_RD;
      end
      ST_ADV_RD: begin
        ram_raddr = ROW_AW'(r_r + HW'(1));
        state_nxt = ST_ADV_WB;
      end
      ST_ADV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = ROW_AW'(r_r);
        ram_wdata = gen_row;
        above_nxt = cur_r;
        cur_nxt   = below;
        r_nxt     = r_r + HW'(1);
        state_nxt = last_row ? ST_DONE : ST_ADV_RD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_cell_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      bw_r        <= DIM_RESET;
      bh_r        <= DIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      bw_r        <= bw_nxt;
      bh_r        <= bh_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_cell_r <= out_cell_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    cell_r     <= cell_nxt;
    r_r        <= r_nxt;
    above_r    <= above_nxt;
    cur_r      <= cur_nxt;
    res_cell_r <= res_cell_nxt;
    res_oor_r  <= res_oor_nxt;
  end

endmodule

[hdl/lbe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lbe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lbe_next_row.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_next_row
// One row of the next generation, one lane per column.
// ----------------------------------------------------------------------------
module lbe_next_row import lbe_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic [CFG_DATA_W-1:0] board_width,
  input  logic [WIDTH-1:0]      above,
  input  logic [WIDTH-1:0]      cur,
  input  logic [WIDTH-1:0]      below,
  output logic [WIDTH-1:0]      next_row
);

  logic [WIDTH-1:0] col_mask;
  logic [WIDTH+1:0] above_p;
  logic [WIDTH+1:0] cur_p;
  logic [WIDTH+1:0] below_p;

  assign above_p = {1'b0, above & col_mask, 1'b0};
  assign cur_p   = {1'b0, cur   & col_mask, 1'b0};
  assign below_p = {1'b0, below & col_mask, 1'b0};

  for (genvar c = 0; c < WIDTH; c++) begin : g_lane
    logic [NBR_W-1:0] nbr;
    logic             alive;

    assign col_mask[c] = 32'(board_width) > c;
    assign nbr = NBR_W'(above_p[c]) + NBR_W'(above_p[c+1]) + NBR_W'(above_p[c+2])
               + NBR_W'(cur_p[c])                          + NBR_W'(cur_p[c+2])
               + NBR_W'(below_p[c]) + NBR_W'(below_p[c+1]) + NBR_W'(below_p[c+2]);
    assign alive = (nbr == BIRTH_COUNT) || ((nbr == SURVIVE_COUNT) && cur_p[c+1]);
    assign next_row[c] = col_mask[c] ? alive : cur[c];
  end

endmodule

[hdl/lbe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_checker
// Port-level checks of the life board engine, bound to the top level.
// ----------------------------------------------------------------------------
module lbe_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_cell,
  input logic out_oor
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_oor_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_oor |-> !out_cell)
    else $error("out of range word carries a live cell");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second in word taken while one is at work");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready && !out_valid)
    else $error("in word taken during clearing pass");

endmodule

bind life_automaton_board_engine_unit lbe_checker u_lbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_cell  (out_if.cell_out),
  .out_oor   (out_if.out_of_range)
);
